// ===== rtl/assert_macros.svh =====
// Assertion macros used by the checker file of this block.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Checks a property on every rising clock edge outside reset.
`define RPUV_ASSERT(label, clk, rstn, prop) \
    label: assert property (@(posedge clk) disable iff (!rstn) prop) \
        else $error("rpuv assertion failed");

// Checks a property on every rising clock edge, reset included.
`define RPUV_ASSERT_ALWAYS(label, clk, prop) \
    label: assert property (@(posedge clk) prop) \
        else $error("rpuv assertion failed");

`endif

// ===== rtl/rpuv_pkg.sv =====
`default_nettype none

package rpuv_pkg;

    localparam int BYTE_W = 8;
    localparam int LEN_W  = 11;
    localparam int CP_W   = 21;

    typedef struct packed {
        logic [1:0]      cont_left;
        logic [1:0]      seq_len;
        logic [CP_W-1:0] cp_accum;
        logic [1:0]      comp_len;
        logic            all_dots;
        logic            prev_slash;
        logic            failed;
    } rpuv_state_t;

    localparam rpuv_state_t STATE_CLEAR = '{
        cont_left:  2'd0,
        seq_len:    2'd0,
        cp_accum:   '0,
        comp_len:   2'd0,
        all_dots:   1'b1,
        prev_slash: 1'b0,
        failed:     1'b0
    };

    localparam logic [LEN_W-1:0] MAX_LENGTH_RESET = 11'd1024;

    localparam logic [BYTE_W-1:0] CHAR_SLASH     = 8'h2F;
    localparam logic [BYTE_W-1:0] CHAR_DOT       = 8'h2E;
    localparam logic [BYTE_W-1:0] CHAR_BACKSLASH = 8'h5C;
    localparam logic [BYTE_W-1:0] CHAR_COMMA     = 8'h2C;
    localparam logic [BYTE_W-1:0] CHAR_DEL       = 8'h7F;
    localparam logic [BYTE_W-1:0] CTRL_LIMIT     = 8'h20;

    localparam logic [BYTE_W-1:0] LEAD2_MIN = 8'hC2;
    localparam logic [BYTE_W-1:0] LEAD2_MAX = 8'hDF;
    localparam logic [BYTE_W-1:0] LEAD3_MIN = 8'hE0;
    localparam logic [BYTE_W-1:0] LEAD3_MAX = 8'hEF;
    localparam logic [BYTE_W-1:0] LEAD4_MIN = 8'hF0;
    localparam logic [BYTE_W-1:0] LEAD4_MAX = 8'hF4;
    localparam logic [BYTE_W-1:0] CONT_MASK = 8'hC0;
    localparam logic [BYTE_W-1:0] CONT_TAG  = 8'h80;

    localparam logic [CP_W-1:0] CP_MIN3 = 21'h000800;
    localparam logic [CP_W-1:0] CP_MIN4 = 21'h010000;
    localparam logic [CP_W-1:0] SURR_LO = 21'h00D800;
    localparam logic [CP_W-1:0] SURR_HI = 21'h00DFFF;
    localparam logic [CP_W-1:0] CP_MAX  = 21'h10FFFF;

    // Sequence kinds, coded as the number of continuation bytes.
    localparam logic [1:0] SEQ_TWO   = 2'd1;
    localparam logic [1:0] SEQ_THREE = 2'd2;
    localparam logic [1:0] SEQ_FOUR  = 2'd3;

    localparam logic [1:0] COMP_SAT = 2'd3;

endpackage

`default_nettype wire

// ===== rtl/rpuv_step.sv =====
`default_nettype none

module rpuv_step (
    input  wire rpuv_pkg::rpuv_state_t       cur,
    input  wire logic [rpuv_pkg::BYTE_W-1:0] path_byte,
    input  wire logic                        has_byte,
    input  wire logic                        first_byte,
    output rpuv_pkg::rpuv_state_t            nxt,
    output logic                             rules_ok
);

    rpuv_pkg::rpuv_state_t        upd;
    logic                         fail;
    logic [rpuv_pkg::CP_W-1:0]    cp_ext;
    logic [1:0]                   cont_dec;
    logic                         dot_cur;
    logic                         dot_nxt;

    always_comb begin
        upd      = cur;
        fail     = 1'b0;
        cp_ext   = {cur.cp_accum[rpuv_pkg::CP_W-7:0], path_byte[5:0]};
        cont_dec = cur.cont_left - 2'd1;
        dot_cur  = cur.all_dots && (cur.comp_len == 2'd1 || cur.comp_len == 2'd2);

        if (first_byte && path_byte != rpuv_pkg::CHAR_SLASH) begin
            fail = 1'b1;
        end
        if (path_byte < rpuv_pkg::CTRL_LIMIT || path_byte == rpuv_pkg::CHAR_DEL ||
            path_byte == rpuv_pkg::CHAR_BACKSLASH || path_byte == rpuv_pkg::CHAR_COMMA) begin
            fail = 1'b1;
        end

        if (cur.cont_left != 2'd0) begin
            if ((path_byte & rpuv_pkg::CONT_MASK) != rpuv_pkg::CONT_TAG) begin
                fail           = 1'b1;
                upd.cont_left  = 2'd0;
            end else begin
                upd.cp_accum  = cp_ext;
                upd.cont_left = cont_dec;
                if (cont_dec == 2'd0) begin
                    if ((cur.seq_len == rpuv_pkg::SEQ_THREE && cp_ext < rpuv_pkg::CP_MIN3) ||
                        (cur.seq_len == rpuv_pkg::SEQ_FOUR && cp_ext < rpuv_pkg::CP_MIN4) ||
                        (cp_ext >= rpuv_pkg::SURR_LO && cp_ext <= rpuv_pkg::SURR_HI) ||
                        cp_ext > rpuv_pkg::CP_MAX) begin
                        fail = 1'b1;
                    end
                end
            end
        end else if (!path_byte[7]) begin
            upd.cont_left = 2'd0;
        end else if (path_byte >= rpuv_pkg::LEAD2_MIN && path_byte <= rpuv_pkg::LEAD2_MAX) begin
            upd.seq_len   = rpuv_pkg::SEQ_TWO;
            upd.cont_left = rpuv_pkg::SEQ_TWO;
            upd.cp_accum  = {16'd0, path_byte[4:0]};
        end else if (path_byte >= rpuv_pkg::LEAD3_MIN && path_byte <= rpuv_pkg::LEAD3_MAX) begin
            upd.seq_len   = rpuv_pkg::SEQ_THREE;
            upd.cont_left = rpuv_pkg::SEQ_THREE;
            upd.cp_accum  = {17'd0, path_byte[3:0]};
        end else if (path_byte >= rpuv_pkg::LEAD4_MIN && path_byte <= rpuv_pkg::LEAD4_MAX) begin
            upd.seq_len   = rpuv_pkg::SEQ_FOUR;
            upd.cont_left = rpuv_pkg::SEQ_FOUR;
            upd.cp_accum  = {18'd0, path_byte[2:0]};
        end else begin
            fail = 1'b1;
        end

        if (path_byte == rpuv_pkg::CHAR_SLASH) begin
            if (!first_byte && (cur.prev_slash || dot_cur)) begin
                fail = 1'b1;
            end
            upd.comp_len   = 2'd0;
            upd.all_dots   = 1'b1;
            upd.prev_slash = 1'b1;
        end else begin
            if (cur.comp_len != rpuv_pkg::COMP_SAT) begin
                upd.comp_len = cur.comp_len + 2'd1;
            end
            if (path_byte != rpuv_pkg::CHAR_DOT) begin
                upd.all_dots = 1'b0;
            end
            upd.prev_slash = 1'b0;
        end

        upd.failed = cur.failed | fail;

        nxt      = has_byte ? upd : cur;
        dot_nxt  = nxt.all_dots && (nxt.comp_len == 2'd1 || nxt.comp_len == 2'd2);
        rules_ok = !nxt.failed && !nxt.prev_slash && nxt.cont_left == 2'd0 && !dot_nxt;
    end

endmodule

`default_nettype wire

// ===== rtl/remote_path_utf8_validator.sv =====
`default_nettype none

// Checks a path that arrives one byte per word (tuser marks a real byte, tlast ends the
// path) and returns one verdict word per path: ok in bit 0, byte count in bits 11:1.
// A word is taken every cycle unless the end word of a path waits on a stalled verdict;
// each goes through an input register and the checking logic, and the verdict for the
// word with tlast goes into the result register. The accepted length is the smaller of the
// cfg_data register and PATH_LIMIT; write the register only while no path is in flight.
module remote_path_utf8_validator #(
    parameter int PATH_LIMIT = 1024
) (
    input  wire logic        aclk,
    input  wire logic        aresetn,
    input  wire logic        cfg_valid,
    output logic             cfg_ready,
    input  wire logic [10:0] cfg_data,    // max_length
    input  wire logic        s_tvalid,
    output logic             s_tready,
    input  wire logic [7:0]  s_tdata,     // path_byte
    input  wire logic        s_tuser,     // has_byte
    input  wire logic        s_tlast,     // last_item
    output logic             m_tvalid,
    input  wire logic        m_tready,
    output logic [15:0]      m_tdata      // path_ok, path_length[10:0], zero fill
);

    localparam int CW = $clog2(PATH_LIMIT + 2);
    localparam int LW = (CW > rpuv_pkg::LEN_W) ? CW : rpuv_pkg::LEN_W;
    localparam logic [CW-1:0] COUNT_SAT = CW'(PATH_LIMIT + 1);
    localparam logic [LW-1:0] LIMIT_CAP = LW'(PATH_LIMIT);

    logic [rpuv_pkg::LEN_W-1:0]  max_length_reg;
    logic                        in_valid_reg;
    logic [rpuv_pkg::BYTE_W-1:0] in_byte_reg;
    logic                        in_has_reg;
    logic                        in_last_reg;
    rpuv_pkg::rpuv_state_t       state_reg;
    rpuv_pkg::rpuv_state_t       state_next;
    rpuv_pkg::rpuv_state_t       step_state;
    logic [CW-1:0]               count_reg;
    logic [CW-1:0]               count_next;
    logic [CW-1:0]               count_step;
    logic                        out_valid_reg;
    logic                        out_ok_reg;
    logic [rpuv_pkg::LEN_W-1:0]  out_len_reg;
    logic                        rules_ok;
    logic                        advance;
    logic [LW-1:0]               limit;
    logic [LW-1:0]               count_wide;
    logic                        verdict;

    rpuv_step u_step (
        .cur        (state_reg),
        .path_byte  (in_byte_reg),
        .has_byte   (in_has_reg),
        .first_byte (count_reg == '0),
        .nxt        (step_state),
        .rules_ok   (rules_ok)
    );

    assign advance   = in_valid_reg && (!in_last_reg || !out_valid_reg || m_tready);
    assign s_tready  = !in_valid_reg || advance;
    assign cfg_ready = 1'b1;
    assign m_tvalid  = out_valid_reg;
    assign m_tdata   = {4'd0, out_len_reg, out_ok_reg};

    always_comb begin
        count_step = count_reg;
        if (in_has_reg && count_reg < COUNT_SAT) begin
            count_step = count_reg + 1'b1;
        end
        limit = (LW'(max_length_reg) < LIMIT_CAP) ? LW'(max_length_reg) : LIMIT_CAP;
        count_wide = LW'(count_step);
        verdict = rules_ok && count_step != '0 && count_wide <= limit;
        state_next = in_last_reg ? rpuv_pkg::STATE_CLEAR : step_state;
        count_next = in_last_reg ? '0 : count_step;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            max_length_reg <= rpuv_pkg::MAX_LENGTH_RESET;
            in_valid_reg   <= 1'b0;
            out_valid_reg  <= 1'b0;
            state_reg      <= rpuv_pkg::STATE_CLEAR;
            count_reg      <= '0;
        end else begin
            if (cfg_valid) begin
                max_length_reg <= cfg_data;
            end
            if (s_tready) begin
                in_valid_reg <= s_tvalid;
            end
            if (advance) begin
                state_reg <= state_next;
                count_reg <= count_next;
            end
            if (advance && in_last_reg) begin
                out_valid_reg <= 1'b1;
            end else if (m_tready) begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (s_tready) begin
            in_byte_reg <= s_tdata;
            in_has_reg  <= s_tuser;
            in_last_reg <= s_tlast;
        end
        if (advance && in_last_reg) begin
            out_ok_reg  <= verdict;
            out_len_reg <= rpuv_pkg::LEN_W'(count_step);
        end
    end

endmodule

`default_nettype wire

// ===== rtl/rpuv_checker.sv =====
`default_nettype none

`include "assert_macros.svh"

module rpuv_checker (
    input wire logic        aclk,
    input wire logic        aresetn,
    input wire logic        s_tvalid,
    input wire logic        s_tready,
    input wire logic        s_tlast,
    input wire logic        m_tvalid,
    input wire logic        m_tready,
    input wire logic [15:0] m_tdata
);

    // No verdict word survives a reset.
    `RPUV_ASSERT_ALWAYS(a_reset_clears, aclk, !aresetn |=> !m_tvalid)

    // A stalled verdict word holds.
    `RPUV_ASSERT(a_out_hold, aclk, aresetn, m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))

    // An accepted path is never empty.
    `RPUV_ASSERT(a_ok_nonempty, aclk, aresetn, m_tvalid && m_tdata[0] |-> m_tdata[11:1] != 11'd0)

    // A fresh verdict follows an accepted end word.
    `RPUV_ASSERT(a_out_cause, aclk, aresetn, $rose(m_tvalid) |-> $past(s_tvalid && s_tready && s_tlast, 2))

    // The fill bits of the verdict word stay zero.
    `RPUV_ASSERT(a_fill_zero, aclk, aresetn, m_tvalid |-> m_tdata[15:12] == 4'd0)

endmodule

bind remote_path_utf8_validator rpuv_checker u_rpuv_checker (
    .aclk     (aclk),
    .aresetn  (aresetn),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tlast  (s_tlast),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata)
);

`default_nettype wire
